/* hdl/prd_pkg.sv */
// Shared types, codes and the ordering rule of the priority request dispatcher.
`timescale 1ns / 1ps

package prd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

  localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
  localparam logic [1:0] MODE_POLL     = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  localparam logic POOL_A = 1'b0;

  typedef enum logic [2:0] {
    K_ACCEPT     = 3'd0,
    K_REJECT     = 3'd1,
    K_DISPATCH   = 3'd2,
    K_NONE       = 3'd3,
    K_RESPONSE   = 3'd4,
    K_UNEXPECTED = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               pool;
    logic [1:0]         priority_req;
    logic [7:0]         vm_id;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [31:0]        arrival_time;
    logic signed [31:0] completion_value;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic               last;
    logic [7:0]         out_vm_id;
    logic               out_pool;
    logic signed [31:0] out_operand_a;
    logic signed [31:0] out_operand_b;
    logic signed [31:0] response_value;
    logic [31:0]        total_done;
    logic [31:0]        pool_a_done;
    logic [31:0]        pool_b_done;
    logic [4:0]         queue_count;
    logic               server_busy;
  } result_t;

  typedef struct packed {
    logic [1:0]  prio;
    logic [31:0] stamp;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               pool;
    logic [7:0]         vm_id;
  } entry_t;

  // True when the new key must stand ahead of the stored one.
  function automatic logic goes_before(input key_t nk, input key_t ck);
    return (nk.prio > ck.prio) || ((nk.prio == ck.prio) && (nk.stamp < ck.stamp));
  endfunction

endpackage

/* hdl/priority_request_dispatcher.sv */
// Top level of the priority request dispatcher: sorted request queue and server tracking.
`timescale 1ns / 1ps

// The block takes one transaction on the command channel when start is high and busy is low.
// The item carries a mode: enqueue a request, poll for a dispatch, or report a completion.
// Results leave on the result port, each one marked by done for exactly one cycle; the
// receiver cannot stall them, so every result must be taken in the cycle it is shown.
// A completion can give two results on consecutive cycles (response, then dispatch);
// the last flag marks the final result of each transaction, and an unused mode gives none.
// Waiting requests sit in a circular buffer memory, kept sorted by priority and arrival.
// An enqueue walks back from the tail with one key comparator, moving one entry per cycle:
// until the request's place is found; into an empty queue it goes straight to the tail,
// and a full queue rejects it. A poll that dispatches passes through a pop step, as the
// head entry comes out of the memory's registered read port; a poll with nothing to do
// answers from the idle state. A completion does too, then pops if it dispatches next.
// Each result is registered, so it appears in the cycle after the one that forms it. busy
// is high in every cycle of work after the accepting one, and low again once the last
// result is formed. Reset empties the queue, clears the server state and zeroes all three
// done counters; the queue memory is not cleared, since only occupied slots are used.
module priority_request_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = prd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  prd_pkg::item_t   item,
  output logic             done,
  output prd_pkg::result_t result
);
  import prd_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] p);
    return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] p);
    return (p == '0) ? IW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  state_t state, state_next;

  item_t   req;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] scan_idx, scan_idx_next;
  logic [CW-1:0] rem, rem_next;
  logic [CW-1:0] count, count_next;
  logic          busy_flag, busy_flag_next;
  logic [8:0]    cur_origin, cur_origin_next;
  logic [31:0]   total, total_next;
  logic [31:0]   pool_a, pool_a_next;
  logic [31:0]   pool_b, pool_b_next;

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  logic    accept;
  logic    full;
  logic    empty;
  logic    ahead;
  entry_t  new_in;
  entry_t  new_req;

  logic               emit;
  kind_t              e_kind;
  logic               e_last;
  logic               e_pool;
  logic [7:0]         e_vm;
  logic signed [31:0] e_a;
  logic signed [31:0] e_b;
  logic signed [31:0] e_resp;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  assign new_in  = '{key: '{prio: item.priority_req, stamp: item.arrival_time},
                     operand_a: item.operand_a, operand_b: item.operand_b,
                     pool: item.pool, vm_id: item.vm_id};
  assign new_req = '{key: '{prio: req.priority_req, stamp: req.arrival_time},
                     operand_a: req.operand_a, operand_b: req.operand_b,
                     pool: req.pool, vm_id: req.vm_id};

  // The single comparator: does the pending request go ahead of the entry just read?
  assign ahead = goes_before(new_req.key, rd_data.key);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.mode)
            MODE_ENQUEUE: begin
              if (!full && !empty) state_next = S_SCAN;
            end
            MODE_POLL: begin
              if (!busy_flag && !empty) state_next = S_POP;
            end
            MODE_COMPLETE: begin
              if (busy_flag && !empty) state_next = S_POP;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!ahead) state_next = S_IDLE;
        else if (rem == CW'(1)) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_IDLE;
      S_POP:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer actions: memory port control, state updates and the result to show.
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    scan_idx_next   = scan_idx;
    rem_next        = rem;
    count_next      = count;
    busy_flag_next  = busy_flag;
    cur_origin_next = cur_origin;
    total_next      = total;
    pool_a_next     = pool_a;
    pool_b_next     = pool_b;
    wr_en           = 1'b0;
    wr_addr         = tail;
    wr_data         = new_req;
    rd_addr         = head;
    emit            = 1'b0;
    e_kind          = K_NONE;
    e_last          = 1'b1;
    e_pool          = 1'b0;
    e_vm            = '0;
    e_a             = '0;
    e_b             = '0;
    e_resp          = '0;
    case (state)
      S_IDLE: begin
        if (item.mode == MODE_ENQUEUE) rd_addr = idx_dec(tail);
        if (accept) begin
          case (item.mode)
            MODE_ENQUEUE: begin
              e_pool = item.pool;
              e_vm   = item.vm_id;
              e_a    = item.operand_a;
              e_b    = item.operand_b;
              if (full) begin
                emit   = 1'b1;
                e_kind = K_REJECT;
              end else if (empty) begin
                wr_en      = 1'b1;
                wr_addr    = tail;
                wr_data    = new_in;
                tail_next  = idx_inc(tail);
                count_next = count + 1'b1;
                emit       = 1'b1;
                e_kind     = K_ACCEPT;
              end else begin
                scan_idx_next = idx_dec(tail);
                rem_next      = count;
              end
            end
            MODE_POLL: begin
              if (busy_flag || empty) begin
                emit   = 1'b1;
                e_kind = K_NONE;
              end
            end
            MODE_COMPLETE: begin
              emit = 1'b1;
              if (!busy_flag) begin
                e_kind = K_UNEXPECTED;
              end else begin
                total_next = total + 1'b1;
                if (cur_origin[8] == POOL_A) pool_a_next = pool_a + 1'b1;
                else pool_b_next = pool_b + 1'b1;
                busy_flag_next  = 1'b0;
                cur_origin_next = '0;
                e_kind          = K_RESPONSE;
                e_last          = empty;
                e_pool          = cur_origin[8];
                e_vm            = cur_origin[7:0];
                e_resp          = item.completion_value;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = idx_dec(scan_idx);
        wr_en   = 1'b1;
        wr_addr = idx_inc(scan_idx);
        if (ahead) begin
          // Move the stored entry one slot toward the tail and keep walking.
          wr_data = rd_data;
          if (rem != CW'(1)) begin
            scan_idx_next = idx_dec(scan_idx);
            rem_next      = rem - 1'b1;
          end
        end else begin
          wr_data    = new_req;
          tail_next  = idx_inc(tail);
          count_next = count + 1'b1;
          emit       = 1'b1;
          e_kind     = K_ACCEPT;
          e_pool     = req.pool;
          e_vm       = req.vm_id;
          e_a        = req.operand_a;
          e_b        = req.operand_b;
        end
      end
      S_PLACE: begin
        // Every waiting entry moved back; the request lands at the head slot.
        wr_en      = 1'b1;
        wr_addr    = scan_idx;
        wr_data    = new_req;
        tail_next  = idx_inc(tail);
        count_next = count + 1'b1;
        emit       = 1'b1;
        e_kind     = K_ACCEPT;
        e_pool     = req.pool;
        e_vm       = req.vm_id;
        e_a        = req.operand_a;
        e_b        = req.operand_b;
      end
      S_POP: begin
        head_next       = idx_inc(head);
        count_next      = count - 1'b1;
        busy_flag_next  = 1'b1;
        cur_origin_next = {rd_data.pool, rd_data.vm_id};
        emit            = 1'b1;
        e_kind          = K_DISPATCH;
        e_pool          = rd_data.pool;
        e_vm            = rd_data.vm_id;
        e_a             = rd_data.operand_a;
        e_b             = rd_data.operand_b;
      end
      default: ;
    endcase
  end

  // Queue storage with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      busy_flag  <= 1'b0;
      cur_origin <= '0;
      total      <= '0;
      pool_a     <= '0;
      pool_b     <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      busy_flag  <= busy_flag_next;
      cur_origin <= cur_origin_next;
      total      <= total_next;
      pool_a     <= pool_a_next;
      pool_b     <= pool_b_next;
      done       <= emit;
    end
  end

  // Payload registers; the result snapshots the state as it stands after this step.
  always_ff @(posedge clk) begin
    if (accept) req <= item;
    scan_idx <= scan_idx_next;
    rem      <= rem_next;
    if (emit) begin
      result.kind           <= e_kind;
      result.last           <= e_last;
      result.out_vm_id      <= e_vm;
      result.out_pool       <= e_pool;
      result.out_operand_a  <= e_a;
      result.out_operand_b  <= e_b;
      result.response_value <= e_resp;
      result.total_done     <= total_next;
      result.pool_a_done    <= pool_a_next;
      result.pool_b_done    <= pool_b_next;
      result.queue_count    <= 5'(count_next);
      result.server_busy    <= busy_flag_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (head == tail))
    else $error("head and tail disagree with count");

  a_scan_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!empty && !full && rem != '0))
    else $error("insertion walk without room or entries");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (!busy_flag && !empty))
    else $error("dispatch while busy or empty");

  a_resp_then_dispatch: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == K_RESPONSE && !result.last)
      |=> (done && result.kind == K_DISPATCH && result.last))
    else $error("response not followed by its dispatch");

endmodule
